[hw/rtl/wlce_pkg.sv]
// Shared word types and fixed constants of the weighted logit cross-entropy core.
package wlce_pkg;

	localparam int LOGIT_W  = 16;
	localparam int TARGET_W = 13;
	localparam int WEIGHT_W = 16;
	localparam int LOSS_W   = 32;

	// Q0.12 target value for a probability of one
	localparam logic [TARGET_W-1:0] TARGET_ONE = 13'd4096;

	typedef struct packed {
		logic signed [LOGIT_W-1:0] logit;
		logic [TARGET_W-1:0]       target;
		logic [WEIGHT_W-1:0]       pos_weight;
	} item_word_t;

	typedef struct packed {
		logic [LOSS_W-1:0] loss;
		logic              saturated;
	} result_word_t;

endpackage

[hw/rtl/weighted_logit_cross_entropy_core.sv]
// Weighted sigmoid cross-entropy core: six-stage pipeline from item word to loss word.
//
// Usage
//  - Item channel (item_valid / item_stall / item): one word per element, carrying the
//    logit x (signed, LOGIT_FRACTION_BITS fraction bits), the target z (Q0.12, values
//    above 4096 count as 4096) and the positive-class weight p (Q8.8).
//  - Result channel (result_valid / result_stall / result): one word per item, in order,
//    with the loss in unsigned Q21.11 and a flag set when the loss was clipped at the top.
//  - Path: an accepted item word moves through the stages in order, and its result word is
//    on the port once it reaches the round and saturate stage; result_stall can hold it there.
//  - Throughput: one word per cycle, sustained. The six register stages (input conditioning,
//    three multipliers, the softplus table lookup, the weight product, the wide sum, round
//    and saturate) each hold one word, so a new item enters every cycle the result side
//    keeps draining.
//  - Stall: when result_stall holds the output stage, words behind it advance into empty
//    stages; item_stall rises only once all six stages are full.
//  - Reset: arst_n clears all stage valid bits at once; the softplus table is a constant
//    and needs no fill, so the core takes items in the first cycle after reset.
//  - The softplus table holds log(1 + exp(-|x|)) for SOFTPLUS_TABLE_ENTRIES buckets over the
//    full logit magnitude range; the logit -32768 falls past the table and reads zero.
module weighted_logit_cross_entropy_core #(
	parameter int SOFTPLUS_TABLE_ENTRIES = 256,
	parameter int LOGIT_FRACTION_BITS    = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  wlce_pkg::item_word_t  item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output wlce_pkg::result_word_t result
);

	import wlce_pkg::*;

	// ---------------------------------------------------------------- widths
	localparam int N      = SOFTPLUS_TABLE_ENTRIES;
	localparam int F      = LOGIT_FRACTION_BITS;
	localparam int IDX_W  = $clog2(N + 1);       // holds N itself for the out-of-table case
	localparam int AW     = $clog2(N);           // table address
	localparam int IPR_W  = LOGIT_W + IDX_W;     // |x| * N
	localparam int SP_W   = F;                   // log(2) in Q.F stays below one
	localparam int SPN_W  = LOGIT_W;             // softplus + max(-x,0) < 2^16
	localparam int PZ_W   = WEIGHT_W + TARGET_W; // p * z
	localparam int T20_W  = PZ_W;                // t in Q8.20
	localparam int T1_W   = TARGET_W + 1 + LOGIT_W; // (1 - z) * x, signed
	localparam int PROD_W = T20_W + SPN_W;
	localparam int ACC_W  = 48;
	localparam int SHIFT  = F + 9;               // Q.(F+20) down to Q.11

	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SHIFT - 1);
	localparam logic [63:0] Q31_ONE   = 64'd1 << 31;
	localparam logic [63:0] EXP_STEP  = (64'd1 << (46 - F)) / N;

	// ---------------------------------------------------------------- table build
	// unsigned quotient by restoring long division, used only while building the table
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-a) in Q.31 for small a by Taylor series
	function automatic logic [63:0] exp_neg_small(input logic [63:0] a);
		longint      sum;
		logic [63:0] term;
		sum  = longint'(Q31_ONE);
		term = Q31_ONE;
		for (int n = 1; n <= 14; n++) begin
			term = div_u64((term * a) >> 31, 64'(n));
			if ((n & 1) != 0)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return (sum < 0) ? 64'd0 : 64'(sum);
	endfunction

	// log(1 + y) in Q.31 through 2 * atanh(y / (2 + y))
	function automatic logic [63:0] log1p_q31(input logic [63:0] y);
		logic [63:0] w;
		logic [63:0] w2;
		logic [63:0] term;
		logic [63:0] acc;
		w    = div_u64(y << 31, (64'd1 << 32) + y);
		w2   = (w * w) >> 31;
		term = w;
		acc  = 64'd0;
		for (int n = 0; n < 24; n++) begin
			acc  = acc + div_u64(term, 64'(2 * n + 1));
			term = (term * w2) >> 31;
		end
		return acc << 1;
	endfunction

	// entry k: exp(-u) stepped k times by the bucket ratio, then log1p, rounded to Q.F
	function automatic logic [63:0] sp_entry(input int k);
		logic [63:0] a;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] v;
		int          m;
		a = EXP_STEP;
		m = 0;
		for (int i = 0; i < 64; i++) begin
			if (a > (64'd1 << 29)) begin
				a = a >> 1;
				m = m + 1;
			end
		end
		r = exp_neg_small(a);
		for (int i = 0; i < 64; i++) begin
			if (i < m)
				r = (r * r) >> 31;
		end
		e = Q31_ONE;
		for (int i = 0; i < k; i++)
			e = (e * r) >> 31;
		v = log1p_q31(e);
		return (v + (64'd1 << (30 - F))) >> (31 - F);
	endfunction

	logic [SP_W-1:0] sp_rom [N];

	for (genvar g = 0; g < N; g++) begin : g_rom
		localparam logic [SP_W-1:0] SP_VAL = SP_W'(sp_entry(g));
		assign sp_rom[g] = SP_VAL;
	end

	// ---------------------------------------------------------------- flow control
	// Each stage loads when it is empty or the stage after it moves on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6;

	assign ok_s6 = !v_s6 || !result_stall;
	assign ok_s5 = !v_s5 || ok_s6;
	assign ok_s4 = !v_s4 || ok_s5;
	assign ok_s3 = !v_s3 || ok_s4;
	assign ok_s2 = !v_s2 || ok_s3;
	assign ok_s1 = !v_s1 || ok_s2;

	assign item_stall = !ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ok_s1) v_s1 <= item_valid;
			if (ok_s2) v_s2 <= v_s1;
			if (ok_s3) v_s3 <= v_s2;
			if (ok_s4) v_s4 <= v_s3;
			if (ok_s5) v_s5 <= v_s4;
			if (ok_s6) v_s6 <= v_s5;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Clamp the target, take |x| and the max(-x, 0) term.
	logic [TARGET_W-1:0] zc_d;
	logic [LOGIT_W-1:0]  ax_d;

	assign zc_d = (item.target > TARGET_ONE) ? TARGET_ONE : item.target;
	assign ax_d = item.logit[LOGIT_W-1] ? (~item.logit + LOGIT_W'(1)) : item.logit;

	logic signed [LOGIT_W-1:0] x_s1;
	logic [TARGET_W-1:0]       z_s1;
	logic [TARGET_W-1:0]       omz_s1;
	logic [WEIGHT_W-1:0]       p_s1;
	logic [LOGIT_W-1:0]        ax_s1;
	logic [LOGIT_W-1:0]        neg_s1;

	always_ff @(posedge clk) begin
		if (ok_s1) begin
			x_s1   <= item.logit;
			z_s1   <= zc_d;
			omz_s1 <= TARGET_ONE - zc_d;
			p_s1   <= item.pos_weight;
			ax_s1  <= ax_d;
			neg_s1 <= item.logit[LOGIT_W-1] ? ax_d : '0;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Three multipliers: table index, p * z and (1 - z) * x.
	logic [IPR_W-1:0] idx_prod;

	assign idx_prod = IPR_W'(ax_s1) * IPR_W'(N);

	logic [IDX_W-1:0]       idx_s2;
	logic [PZ_W-1:0]        pz_s2;
	logic signed [T1_W-1:0] t1p_s2;
	logic [TARGET_W-1:0]    omz_s2;
	logic [LOGIT_W-1:0]     neg_s2;

	always_ff @(posedge clk) begin
		if (ok_s2) begin
			idx_s2 <= IDX_W'(idx_prod >> 15);
			pz_s2  <= PZ_W'(p_s1) * PZ_W'(z_s1);
			t1p_s2 <= T1_W'($signed({1'b0, omz_s1})) * T1_W'(x_s1);
			omz_s2 <= omz_s1;
			neg_s2 <= neg_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Table lookup (zero past the last bucket), add max(-x,0); form t in Q8.20.
	logic [SP_W-1:0] sp_rd;

	assign sp_rd = (idx_s2 < IDX_W'(N)) ? sp_rom[idx_s2[AW-1:0]] : '0;

	logic [SPN_W-1:0]       spn_s3;
	logic [T20_W-1:0]       t20_s3;
	logic signed [T1_W-1:0] t1p_s3;

	always_ff @(posedge clk) begin
		if (ok_s3) begin
			spn_s3 <= SPN_W'(sp_rd) + neg_s2;
			t20_s3 <= (T20_W'(omz_s2) << 8) + pz_s2;
			t1p_s3 <= t1p_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4
	logic [PROD_W-1:0]      prod_s4;
	logic signed [T1_W-1:0] t1p_s4;

	always_ff @(posedge clk) begin
		if (ok_s4) begin
			prod_s4 <= PROD_W'(t20_s3) * PROD_W'(spn_s3);
			t1p_s4  <= t1p_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5
	// Exact sum in Q.(F+20).
	logic signed [ACC_W-1:0] acc_s5;

	always_ff @(posedge clk) begin
		if (ok_s5)
			acc_s5 <= $signed({{(ACC_W - T1_W - 8){t1p_s4[T1_W-1]}}, t1p_s4, 8'b0})
				+ $signed({{(ACC_W - PROD_W){1'b0}}, prod_s4});
	end

	// ---------------------------------------------------------------- stage 6
	// Clamp at zero, round half up to Q.11, saturate at the top of the loss range.
	logic [ACC_W-1:0] rnd;
	logic [ACC_W-1:0] shifted;
	logic             ovf;

	assign rnd     = {1'b0, acc_s5[ACC_W-2:0]} + HALF;
	assign shifted = rnd >> SHIFT;
	assign ovf     = |shifted[ACC_W-1:LOSS_W];

	logic [LOSS_W-1:0] loss_s6;
	logic              sat_s6;

	always_ff @(posedge clk) begin
		if (ok_s6) begin
			if (acc_s5[ACC_W-1]) begin
				loss_s6 <= '0;
				sat_s6  <= 1'b0;
			end else begin
				loss_s6 <= ovf ? '1 : shifted[LOSS_W-1:0];
				sat_s6  <= ovf;
			end
		end
	end

	assign result_valid     = v_s6;
	assign result.loss      = loss_s6;
	assign result.saturated = sat_s6;

	// ---------------------------------------------------------------- checks
	// A clipped loss always reads as all ones.
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |-> result.loss == '1)
		else $error("saturated loss word is not at the top of the range");

	// Items are held off only when every stage holds a word and the output is stalled.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && result_stall)
		else $error("item stalled while the pipeline has room");

	// An unstalled output stage takes whatever stage 5 held.
	a_out_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!(result_valid && result_stall) |=> result_valid == $past(v_s5))
		else $error("output stage lost or repeated a word");

	// The weighted sum cannot go negative.
	a_acc_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> !acc_s5[ACC_W-1])
		else $error("negative loss sum");

endmodule

[test/tb_top.sv]
// Self-checking regression bench for the weighted logit cross-entropy core.
`timescale 1ns / 100ps

module tb_top;
	import wlce_pkg::*;

	typedef longint unsigned u64_t;

	localparam int LUT_SIZE      = 256;
	localparam int LOGIT_FRAC    = 11;
	localparam int OUT_SHIFT     = LOGIT_FRAC + 20 - 11;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int HOLD_CYCLES   = 80;
	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam u64_t Q31_ONE     = u64_t'(1) << 31;

	// Golden loss calculator plus the queue of loss words still owed by the core.
	class loss_scoreboard;
		result_word_t pending_losses[$];
		bit [31:0] softplus_lut[LUT_SIZE];
		int unsigned fail_count;

		function new();
			build_softplus_lut();
		endfunction

		// exp(-a) in Q.31 for small a, truncated Taylor series
		function u64_t exp_neg_q31(u64_t a);
			longint sum;
			u64_t term;
			sum = longint'(Q31_ONE);
			term = Q31_ONE;
			for (int n = 1; n <= 14; n++) begin
				term = ((term * a) >> 31) / u64_t'(n);
				if (n % 2 == 1)
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			return (sum < 0) ? u64_t'(0) : u64_t'(sum);
		endfunction

		// log(1 + y) in Q.31 through the atanh series
		function u64_t log1p_q31(u64_t y);
			u64_t w, w2, term, acc;
			w = (y << 31) / ((u64_t'(1) << 32) + y);
			w2 = (w * w) >> 31;
			term = w;
			acc = 0;
			for (int n = 0; n < 24; n++) begin
				acc += term / u64_t'(2 * n + 1);
				term = (term * w2) >> 31;
			end
			return acc * 2;
		endfunction

		function void build_softplus_lut();
			u64_t a, r, e, v;
			int shifts;
			a = (u64_t'(1) << (46 - LOGIT_FRAC)) / u64_t'(LUT_SIZE);
			shifts = 0;
			while (a > (u64_t'(1) << 29)) begin
				a >>= 1;
				shifts++;
			end
			r = exp_neg_q31(a);
			repeat (shifts) r = (r * r) >> 31;
			e = Q31_ONE;
			for (int k = 0; k < LUT_SIZE; k++) begin
				v = log1p_q31(e);
				softplus_lut[k] = 32'((v + (u64_t'(1) << (30 - LOGIT_FRAC))) >> (31 - LOGIT_FRAC));
				e = (e * r) >> 31;
			end
		endfunction

		function result_word_t predict_loss(item_word_t w);
			longint x, z, p, ax, idx, sp, neg, t20, acc;
			u64_t rounded;
			result_word_t r;
			x = longint'($signed(w.logit));
			z = longint'(w.target);
			p = longint'(w.pos_weight);
			if (z > longint'(TARGET_ONE))
				z = longint'(TARGET_ONE);
			ax = (x < 0) ? -x : x;
			idx = (ax * LUT_SIZE) >> 15;
			sp = (idx < LUT_SIZE) ? longint'(softplus_lut[idx]) : 0;
			neg = (x < 0) ? ax : 0;
			t20 = (longint'(TARGET_ONE) - z) * 256 + p * z;
			acc = (longint'(TARGET_ONE) - z) * x * 256 + t20 * (sp + neg);
			if (acc < 0)
				acc = 0;
			rounded = (u64_t'(acc) + (u64_t'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
			r.saturated = 1'b0;
			if (rounded > u64_t'(32'hFFFF_FFFF)) begin
				rounded = u64_t'(32'hFFFF_FFFF);
				r.saturated = 1'b1;
			end
			r.loss = rounded[31:0];
			return r;
		endfunction

		function void note_item(item_word_t w);
			pending_losses.push_back(predict_loss(w));
		endfunction

		function void check_loss(result_word_t got);
			result_word_t want;
			if (pending_losses.size() == 0) begin
				$error("loss word with nothing outstanding: loss=%0d saturated=%0d",
					got.loss, got.saturated);
				fail_count++;
				return;
			end
			want = pending_losses.pop_front();
			if (got.loss !== want.loss) begin
				$error("loss: expected %0d, actual %0d", want.loss, got.loss);
				fail_count++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
				fail_count++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         item_valid;
	logic         item_stall;
	item_word_t   item;
	logic         result_valid;
	logic         result_stall;
	result_word_t result;

	loss_scoreboard sb = new();

	// Shared pacing knobs: quiet_phase turns off idling on both sides,
	// hold_request asks the receiver for one long hold-off.
	bit quiet_phase;
	bit hold_request;
	int hold_left;
	int unsigned cycle_count;

	weighted_logit_cross_entropy_core #(
		.SOFTPLUS_TABLE_ENTRIES(LUT_SIZE),
		.LOGIT_FRACTION_BITS(LOGIT_FRAC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels; a word moves on an edge where valid is high and stall low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_loss(result);
		end
	end

	// Offer one word and hold it steady until the core takes it; idle first at random.
	task automatic send_item(input item_word_t w);
		while (!quiet_phase && $urandom_range(99) < 30) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	function automatic item_word_t pack_item(int x, int z, int p);
		item_word_t w;
		w.logit = x[15:0];
		w.target = z[12:0];
		w.pos_weight = p[15:0];
		return w;
	endfunction

	// Weight the logit toward the region where the softplus table matters most,
	// keep most targets legal and let a fifth run over the whole 13-bit field.
	function automatic item_word_t random_item();
		int x, z, p;
		case ($urandom_range(9))
			0: x = ($urandom_range(1) == 0) ? -32768 : 32767;
			1, 2: x = $urandom_range(4095) - 2048;
			default: x = $urandom_range(65535) - 32768;
		endcase
		case ($urandom_range(9))
			0: z = ($urandom_range(1) == 0) ? 0 : 4096;
			1, 2: z = $urandom_range(8191);
			default: z = $urandom_range(4096);
		endcase
		case ($urandom_range(7))
			0: p = 256;
			1: p = $urandom_range(511);
			default: p = $urandom_range(65535);
		endcase
		return pack_item(x, z, p);
	endfunction

	// Field extremes, the target clamp, the logit past the table edge and the
	// zero-weight case that drives the sum to exactly zero.
	task automatic run_directed_items();
		send_item(pack_item(0, 0, 256));
		send_item(pack_item(0, 4096, 256));
		send_item(pack_item(32767, 0, 256));
		send_item(pack_item(32767, 4096, 65535));
		send_item(pack_item(-32768, 0, 256));
		send_item(pack_item(-32768, 4096, 65535));
		send_item(pack_item(-32768, 4096, 0));
		send_item(pack_item(-32768, 8191, 65535));
		send_item(pack_item(-32767, 4096, 65535));
		send_item(pack_item(-1, 2048, 256));
		send_item(pack_item(1, 2048, 256));
		send_item(pack_item(-2048, 4096, 512));
		send_item(pack_item(2048, 0, 0));
		send_item(pack_item(0, 4097, 256));
		send_item(pack_item(-100, 8191, 65535));
		send_item(pack_item(32767, 8191, 0));
		send_item(pack_item(-32767, 1, 1));
		send_item(pack_item(16384, 4095, 65535));
		send_item(pack_item(-16384, 4095, 65535));
		send_item(pack_item(5, 4096, 0));
		send_item(pack_item(-5, 0, 65535));
		send_item(pack_item(127, 4096, 32768));
	endtask

	// Receiver: stall at random, or hold off for a long counted stretch on request
	// so the pipeline fills and pushes back on the item side.
	initial begin
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= !quiet_phase && ($urandom_range(99) < 30);
			end
		end
	end

	// Watchdog: report a fail and stop once the cycle counter reaches CYCLE_LIMIT, so a stuck run cannot hang.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("weighted_logit_cross_entropy_core regression: fail");
		$finish;
	end

	// Main sequence: reset, directed words, random words, drain, verdict.
	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		quiet_phase = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed_items();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// hold a long stretch with no idling on either side
			quiet_phase = (n >= 500 && n < 700);
			if (n == 150 || n == 900)
				hold_request = 1'b1;
			send_item(random_item());
		end
		item_valid <= 1'b0;
		@(posedge clk);

		// advance until every predicted loss word has come back, then let the pipe settle
		while (sb.pending_losses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.fail_count == 0 && sb.pending_losses.size() == 0)
			$display("weighted_logit_cross_entropy_core regression: pass");
		else
			$display("weighted_logit_cross_entropy_core regression: fail");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/wlce_pkg.sv
hw/rtl/weighted_logit_cross_entropy_core.sv
test/tb_top.sv
